/* hw/rtl/sphk_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sphk_pkg
// Shared types, codes, constants and pseudo-float helpers of the cubic-spline
// SPH kernel pipeline.
// ----------------------------------------------------------------------------
package sphk_pkg;

	localparam int IN_FRAC_BITS = 20;
	localparam int EXP_W = 10;

	// request codes
	localparam logic [2:0] REQ_VALUE = 3'd0;
	localparam logic [2:0] REQ_D1    = 3'd1;
	localparam logic [2:0] REQ_D2    = 3'd2;
	localparam logic [2:0] REQ_SELF  = 3'd3;
	localparam logic [2:0] REQ_GRAD  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	// derivative order
	localparam logic [1:0] ORD_W  = 2'd0;
	localparam logic [1:0] ORD_D1 = 2'd1;
	localparam logic [1:0] ORD_D2 = 2'd2;

	localparam int DIV_ITERS = 33;
	localparam int DIV_PER_STAGE = 3;
	localparam int DIV_STAGES = DIV_ITERS / DIV_PER_STAGE;
	localparam int PIPE_LAT = DIV_STAGES + 10;

	localparam logic signed [EXP_W-1:0] INVH_EXP_BIAS = EXP_W'(IN_FRAC_BITS + 1 - 63);
	localparam logic signed [EXP_W-1:0] PF_EXP_Q30 = -EXP_W'(30);

	localparam logic [31:0] SIG1_M = 32'd2863311531;
	localparam logic [31:0] SIG2_M = 32'd3906087289;
	localparam logic [31:0] SIG3_M = 32'd2734261102;
	localparam logic signed [EXP_W-1:0] SIG1_E = -EXP_W'(32);
	localparam logic signed [EXP_W-1:0] SIG23_E = -EXP_W'(33);

	localparam logic [47:0] MAG_POS = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] MAG_NEG = 48'h8000_0000_0000;

	typedef struct packed {
		logic [31:0] m;
		logic signed [EXP_W-1:0] e;
	} pf_t;

	typedef struct packed {
		logic [2:0] req;
		logic zs;
		logic lt1;
		logic lt2;
		logic [1:0] order;
		logic [2:0] k;
		logic [1:0] dim;
		logic [4:0] lz;
		pf_t dx;
		pf_t dy;
		pf_t dz;
		logic nx;
		logic ny;
		logic nz;
	} side_t;

	function automatic logic [4:0] lzc32(logic [31:0] x);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) n = 5'(31 - i);
		end
		return n;
	endfunction

	function automatic pf_t pf_make32(logic [31:0] x, logic signed [EXP_W-1:0] base);
		pf_t r;
		logic [4:0] lz;
		lz = lzc32(x);
		r.m = x << lz;
		r.e = base - $signed({{(EXP_W-5){1'b0}}, lz});
		if (x == '0) r = '0;
		return r;
	endfunction

	function automatic pf_t pf_mul(pf_t a, pf_t b);
		pf_t r;
		logic [63:0] p;
		p = 64'(a.m) * 64'(b.m);
		if (p[63]) begin
			r.m = p[63:32];
			r.e = a.e + b.e + EXP_W'(32);
		end else begin
			r.m = p[62:31];
			r.e = a.e + b.e + EXP_W'(31);
		end
		if (a.m == '0 || b.m == '0) r = '0;
		return r;
	endfunction

	// returns {saturated, two's complement Q24.24}
	function automatic logic [48:0] pf_to_out(pf_t a, logic neg);
		logic signed [EXP_W:0] sh;
		logic [EXP_W:0] n;
		logic [5:0] nm1;
		logic [32:0] t;
		logic [47:0] v;
		logic sat;
		sh = (EXP_W+1)'(a.e) + (EXP_W+1)'(24);
		n = (EXP_W+1)'(-sh);
		nm1 = n[5:0] - 6'd1;
		sat = 1'b0;
		v = '0;
		t = '0;
		if (a.m == '0) begin
			v = '0;
		end else if (sh > (EXP_W+1)'(15)) begin
			v = neg ? MAG_NEG : MAG_POS;
			sat = 1'b1;
		end else if (sh >= 0) begin
			v = 48'(a.m) << sh[3:0];
		end else if (n < (EXP_W+1)'(34)) begin
			t = ({1'b0, a.m} + (33'd1 << nm1)) >> n[5:0];
			v = 48'(t);
		end
		if (neg) v = ~v + 48'd1;
		return {sat, v};
	endfunction

	// DIV_PER_STAGE restoring-division steps; returns {quotient, remainder}
	function automatic logic [64:0] div_steps(logic [31:0] rem, logic [31:0] dvs,
			logic [32:0] quo);
		logic [32:0] t;
		logic [31:0] r;
		logic [32:0] qq;
		r = rem;
		qq = quo;
		for (int i = 0; i < DIV_PER_STAGE; i++) begin
			t = {r, 1'b0};
			if (t >= {1'b0, dvs}) begin
				r = 32'(t - {1'b0, dvs});
				qq = {qq[31:0], 1'b1};
			end else begin
				r = t[31:0];
				qq = {qq[31:0], 1'b0};
			end
		end
		return {qq, r};
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/sph_cubic_spline_kernel.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sph_cubic_spline_kernel
// Cubic-spline SPH kernel: value, derivatives, self value and gradient.
// ----------------------------------------------------------------------------
// One particle pair enters per clock and its result appears on the result
// ports together with done, which marks it for one cycle. busy is always
// low and the receiver cannot stall. The pipeline runs the 33-step divider
// at three steps per stage (11 stages), followed by the chain of five
// pseudo-float multiplies that raise 1/h to its power, the polynomial
// multiply, the direction multiply and the Q24.24 conversion.
module sph_cubic_spline_kernel (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         req_type,
	input  logic [31:0]        distance,
	input  logic [31:0]        support,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_data,
	output logic               done,
	output logic signed [47:0] primary,
	output logic signed [47:0] grad_y,
	output logic signed [47:0] grad_z,
	output logic [1:0]         status
);
	import sphk_pkg::*;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	logic [1:0] dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= 2'd3;
		end else if (cfg_valid && cfg_ready) begin
			dim_q <= cfg_data;
		end
	end

	// ---------------- stage 1: decode, normalize support and directions
	side_t side_in;
	logic [4:0] s_lz;
	logic [31:0] dmx, dmy, dmz;

	always_comb begin
		s_lz = lzc32(support);
		side_in.req = req_type;
		side_in.zs = (support == '0);
		side_in.lt2 = distance < support;
		side_in.lt1 = {distance, 1'b0} < {1'b0, support};
		case (req_type) inside
			REQ_VALUE, REQ_SELF: side_in.order = ORD_W;
			REQ_D2: side_in.order = ORD_D2;
			default: side_in.order = ORD_D1;
		endcase
		unique case (dim_q)
			2'd1: side_in.dim = 2'd1;
			2'd2: side_in.dim = 2'd2;
			default: side_in.dim = 2'd3;
		endcase
		side_in.k = 3'(side_in.dim) + 3'(side_in.order);
		side_in.lz = s_lz;
		dmx = dir_x[31] ? 32'(~dir_x + 32'sd1) : 32'(dir_x);
		dmy = dir_y[31] ? 32'(~dir_y + 32'sd1) : 32'(dir_y);
		dmz = dir_z[31] ? 32'(~dir_z + 32'sd1) : 32'(dir_z);
		side_in.dx = pf_make32(dmx, PF_EXP_Q30);
		side_in.dy = pf_make32(dmy, PF_EXP_Q30);
		side_in.dz = pf_make32(dmz, PF_EXP_Q30);
		side_in.nx = dir_x[31];
		side_in.ny = dir_y[31];
		side_in.nz = dir_z[31];
	end

	logic vld_s1;
	side_t side_s1;
	logic [31:0] rem_s1, s_s1, m_s1;

	always_ff @(posedge clk) begin
		side_s1 <= side_in;
		rem_s1 <= side_in.lt2 ? distance : '0;
		s_s1 <= support;
		m_s1 <= support << s_lz;
	end

	// ---------------- divider stages
	logic [30:0] div_q;
	logic [32:0] div_r;

	sphk_div u_div (
		.clk   (clk),
		.q_rem (rem_s1),
		.q_dvs (s_s1),
		.r_dvs (m_s1),
		.q     (div_q),
		.r     (div_r)
	);

	logic  vdly_q [DIV_STAGES];
	side_t sdly_q [DIV_STAGES];

	always_ff @(posedge clk) begin
		sdly_q[0] <= side_s1;
		for (int i = 1; i < DIV_STAGES; i++) sdly_q[i] <= sdly_q[i-1];
	end

	// ---------------- stage 2: 1/h, polynomial argument, sigma
	side_t sd_out;
	pf_t invh_c, sig_c;
	logic [30:0] x_c;

	always_comb begin
		sd_out = sdly_q[DIV_STAGES-1];
		invh_c.m = div_r[32] ? 32'h8000_0000 : div_r[31:0];
		invh_c.e = INVH_EXP_BIAS + $signed({{(EXP_W-5){1'b0}}, sd_out.lz})
			+ $signed({{(EXP_W-1){1'b0}}, div_r[32]});
		x_c = sd_out.lt1 ? div_q : 31'(32'h8000_0000 - {1'b0, div_q});
		unique case (sd_out.dim)
			2'd1: sig_c = '{m: SIG1_M, e: SIG1_E};
			2'd2: sig_c = '{m: SIG2_M, e: SIG23_E};
			default: sig_c = '{m: SIG3_M, e: SIG23_E};
		endcase
	end

	logic vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	side_t side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8, side_s9;
	pf_t invh_s2, invh_s3, invh_s4, invh_s5, invh_s6;
	pf_t acc_s2, acc_s3, acc_s4, acc_s5, acc_s6, acc_s7, acc_s8;
	logic [30:0] x_s2, x_s3, x_s4, x2_s3, x2_s4, x3_s4;
	logic [31:0] pmag_s5;
	pf_t pm_s6, pm_s7;
	logic neg_s5, neg_s6, neg_s7, neg_s8;
	pf_t lane_s9 [3];
	logic lneg_s9 [3];

	// polynomial magnitude from x, x^2, x^3
	logic [34:0] ex, ex2, ex3, pos, pm_c;
	logic neg_c;
	localparam logic [34:0] QONE = 35'h0_4000_0000;

	always_comb begin
		ex = 35'(x_s4);
		ex2 = 35'(x2_s4);
		ex3 = 35'(x3_s4);
		pos = (ex * 35'd9) >> 1;
		pm_c = '0;
		neg_c = 1'b0;
		if (side_s4.req == REQ_SELF) begin
			pm_c = QONE;
		end else if (side_s4.lt2 && side_s4.lt1) begin
			case (side_s4.order)
				ORD_W: pm_c = QONE + ((ex3 * 35'd3) >> 2) - ((ex2 * 35'd3) >> 1);
				ORD_D1: begin
					pm_c = ex * 35'd3 - ((ex2 * 35'd9) >> 2);
					neg_c = 1'b1;
				end
				default: begin
					if (pos >= QONE * 35'd3) begin
						pm_c = pos - QONE * 35'd3;
					end else begin
						pm_c = QONE * 35'd3 - pos;
						neg_c = 1'b1;
					end
				end
			endcase
		end else if (side_s4.lt2) begin
			case (side_s4.order)
				ORD_W: pm_c = ex3 >> 2;
				ORD_D1: begin
					pm_c = (ex2 * 35'd3) >> 2;
					neg_c = 1'b1;
				end
				default: pm_c = (ex * 35'd3) >> 1;
			endcase
		end
	end

	logic [61:0] px2, px3;
	assign px2 = 62'(x_s2) * 62'(x_s2);
	assign px3 = 62'(x2_s3) * 62'(x_s3);

	always_ff @(posedge clk) begin
		// stage 2
		side_s2 <= sd_out;
		invh_s2 <= invh_c;
		acc_s2 <= sig_c;
		x_s2 <= x_c;
		// stages 3..7: sigma times 1/h, k times in order
		side_s3 <= side_s2;
		invh_s3 <= invh_s2;
		acc_s3 <= (side_s2.k > 3'd0) ? pf_mul(acc_s2, invh_s2) : acc_s2;
		side_s4 <= side_s3;
		invh_s4 <= invh_s3;
		acc_s4 <= (side_s3.k > 3'd1) ? pf_mul(acc_s3, invh_s3) : acc_s3;
		side_s5 <= side_s4;
		invh_s5 <= invh_s4;
		acc_s5 <= (side_s4.k > 3'd2) ? pf_mul(acc_s4, invh_s4) : acc_s4;
		side_s6 <= side_s5;
		invh_s6 <= invh_s5;
		acc_s6 <= (side_s5.k > 3'd3) ? pf_mul(acc_s5, invh_s5) : acc_s5;
		side_s7 <= side_s6;
		acc_s7 <= (side_s6.k > 3'd4) ? pf_mul(acc_s6, invh_s6) : acc_s6;
		// polynomial alongside the chain
		x_s3 <= x_s2;
		x2_s3 <= px2[60:30];
		x_s4 <= x_s3;
		x2_s4 <= x2_s3;
		x3_s4 <= px3[60:30];
		pmag_s5 <= pm_c[31:0];
		neg_s5 <= neg_c;
		pm_s6 <= pf_make32(pmag_s5, PF_EXP_Q30);
		neg_s6 <= neg_s5;
		pm_s7 <= pm_s6;
		neg_s7 <= neg_s6;
		// stage 8: times polynomial
		side_s8 <= side_s7;
		acc_s8 <= pf_mul(acc_s7, pm_s7);
		neg_s8 <= neg_s7;
		// stage 9: times direction for the gradient
		side_s9 <= side_s8;
		if (side_s8.req == REQ_GRAD) begin
			lane_s9[0] <= pf_mul(acc_s8, side_s8.dx);
			lane_s9[1] <= pf_mul(acc_s8, side_s8.dy);
			lane_s9[2] <= pf_mul(acc_s8, side_s8.dz);
			lneg_s9[0] <= neg_s8 ^ side_s8.nx;
			lneg_s9[1] <= neg_s8 ^ side_s8.ny;
			lneg_s9[2] <= neg_s8 ^ side_s8.nz;
		end else begin
			lane_s9[0] <= acc_s8;
			lane_s9[1] <= '0;
			lane_s9[2] <= '0;
			lneg_s9[0] <= neg_s8;
			lneg_s9[1] <= 1'b0;
			lneg_s9[2] <= 1'b0;
		end
	end

	// ---------------- stage 10: fixed-point conversion
	logic [48:0] cv [3];
	logic sat_c;

	always_comb begin
		for (int i = 0; i < 3; i++) cv[i] = pf_to_out(lane_s9[i], lneg_s9[i]);
		sat_c = cv[0][48] | cv[1][48] | cv[2][48];
	end

	always_ff @(posedge clk) begin
		if (side_s9.req > REQ_GRAD) begin
			primary <= '0;
			grad_y <= '0;
			grad_z <= '0;
			status <= ST_OK;
		end else if (side_s9.zs) begin
			primary <= '0;
			grad_y <= '0;
			grad_z <= '0;
			status <= ST_ZERO;
		end else begin
			primary <= cv[0][47:0];
			grad_y <= cv[1][47:0];
			grad_z <= cv[2][47:0];
			status <= sat_c ? ST_SAT : ST_OK;
		end
	end

	// valid bits travel with the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < DIV_STAGES; i++) vdly_q[i] <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vdly_q[0] <= vld_s1;
			for (int i = 1; i < DIV_STAGES; i++) vdly_q[i] <= vdly_q[i-1];
			vld_s2 <= vdly_q[DIV_STAGES-1];
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			done <= vld_s9;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/sphk_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sphk_div
// Pipelined restoring divider pair: q = d*2^31/s and r = 2^63/m, three
// quotient bits per stage.
// ----------------------------------------------------------------------------
module sphk_div (
	input  logic        clk,
	input  logic [31:0] q_rem,
	input  logic [31:0] q_dvs,
	input  logic [31:0] r_dvs,
	output logic [30:0] q,
	output logic [32:0] r
);
	import sphk_pkg::*;

	logic [31:0] qrem_q [DIV_STAGES];
	logic [31:0] qdvs_q [DIV_STAGES];
	logic [32:0] qquo_q [DIV_STAGES];
	logic [31:0] rrem_q [DIV_STAGES];
	logic [31:0] rdvs_q [DIV_STAGES];
	logic [32:0] rquo_q [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_st
		logic [31:0] qr_in, qd_in, rr_in, rd_in;
		logic [32:0] qq_in, rq_in;
		if (g == 0) begin : g_first
			assign qr_in = q_rem;
			assign qd_in = q_dvs;
			assign qq_in = '0;
			assign rr_in = 32'h4000_0000;
			assign rd_in = r_dvs;
			assign rq_in = '0;
		end else begin : g_next
			assign qr_in = qrem_q[g-1];
			assign qd_in = qdvs_q[g-1];
			assign qq_in = qquo_q[g-1];
			assign rr_in = rrem_q[g-1];
			assign rd_in = rdvs_q[g-1];
			assign rq_in = rquo_q[g-1];
		end
		always_ff @(posedge clk) begin
			{qquo_q[g], qrem_q[g]} <= div_steps(qr_in, qd_in, qq_in);
			{rquo_q[g], rrem_q[g]} <= div_steps(rr_in, rd_in, rq_in);
			qdvs_q[g] <= qd_in;
			rdvs_q[g] <= rd_in;
		end
	end

	// two extra quotient bits on q are dropped
	assign q = qquo_q[DIV_STAGES-1][32:2];
	assign r = rquo_q[DIV_STAGES-1];

endmodule
`default_nettype wire

/* hw/rtl/sphk_check.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sphk_check
// Port-level checks of the SPH kernel: fixed latency and result sanity.
// ----------------------------------------------------------------------------
module sphk_check (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [2:0]         req_type,
	input logic [31:0]        support,
	input logic               done,
	input logic signed [47:0] primary,
	input logic signed [47:0] grad_y,
	input logic signed [47:0] grad_z,
	input logic [1:0]         status
);
	import sphk_pkg::*;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("accepted beat gave no result at the fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without an accepted beat");

	a_grad_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (grad_y != 0 || grad_z != 0)) |-> $past(req_type, PIPE_LAT) == REQ_GRAD)
		else $error("gradient lanes nonzero for a scalar request");

	a_zero_support: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(support, PIPE_LAT) == 0 && $past(req_type, PIPE_LAT) <= REQ_GRAD)
		|-> (status == ST_ZERO && primary == 0 && grad_y == 0 && grad_z == 0))
		else $error("zero support not flagged");

endmodule

bind sph_cubic_spline_kernel sphk_check u_check (.*);
`default_nettype wire
